[hw/rtl/lpba_pkg.sv]
package lpba_pkg;

   localparam int MASK_W = 4;
   localparam int LOCK_W = 2;
   localparam int LOCKS_W = 2 * MASK_W;
   localparam int IDX_W = 2;
   localparam int RULE_W = 2;
   localparam int CNT_W = 32;
   localparam int REQ_CNT_W = 3;
   localparam int NUM_MASTERS_DEFAULT = 4;

   localparam logic [LOCK_W-1:0] LOCK_NONE = 2'd0;
   localparam logic [LOCK_W-1:0] LOCK_SET = 2'd1;
   localparam logic [LOCK_W-1:0] LOCK_GRANTED = 2'd2;

   typedef enum logic [RULE_W-1:0] {
      RULE_NONE = 2'd0,
      RULE_BURST = 2'd1,
      RULE_HELD = 2'd2,
      RULE_PRIORITY = 2'd3
   } rule_type;

   typedef struct packed {
      logic [MASK_W-1:0] request_mask;
      logic [MASK_W-1:0] wait_mask;
      logic [LOCKS_W-1:0] lock_states;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] grant_index;
      logic [RULE_W-1:0] rule_used;
      logic [LOCK_W-1:0] winner_lock_out;
      logic [CNT_W-1:0] decisions_total;
      logic [CNT_W-1:0] rejections_total;
      logic [CNT_W-1:0] winner_grant_count;
   } rsp_type;

   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
      logic [CNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
   endfunction

endpackage

[hw/rtl/locked_priority_bus_arbiter_core.sv]
// Fixed-priority bus arbiter with bus lock. Each request beat is one arbitration
// round: the lowest waiting master with its lock set wins first, then the lowest
// requester already holding a granted lock, then the lowest requester, whose set
// lock is promoted to granted. Saturating counters track decisions, rejections and
// grants per master; an empty request mask grants nothing and leaves them alone.
// One beat is taken every cycle while the response side is not stalled; each beat
// passes the input register, then the response register, and the per-round counter
// update in the arbitration stage keeps that one-round-per-cycle rate. Only the lowest
// min(NUM_MASTERS, 4) mask bits take part.
module locked_priority_bus_arbiter_core
   import lpba_pkg::*;
#(
   parameter int NUM_MASTERS = NUM_MASTERS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int ACTIVE = (NUM_MASTERS > MASK_W) ? MASK_W : NUM_MASTERS;
   localparam int WIN_W = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;
   localparam logic [MASK_W-1:0] ACTIVE_MASK = MASK_W'((1 << ACTIVE) - 1);

   logic             stage_valid_ff;
   req_type          stage_data_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;
   logic [CNT_W-1:0] decision_cnt_ff;
   logic [CNT_W-1:0] rejection_cnt_ff;
   logic [CNT_W-1:0] grant_cnt_ff [ACTIVE];

   logic             advance;
   logic             fire;
   logic [MASK_W-1:0] req_act;
   logic [REQ_CNT_W-1:0] req_count;
   logic             found;
   logic [WIN_W-1:0] winner;
   rule_type         rule;
   logic [LOCK_W-1:0] lock_out;
   logic [CNT_W-1:0] decision_cnt_in;
   logic [CNT_W-1:0] rejection_cnt_in;
   logic [CNT_W-1:0] grant_cnt_in;
   rsp_type          rsp_data_in;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !stage_valid_ff || advance;
   assign fire      = stage_valid_ff && advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      req_act   = stage_data_ff.request_mask & ACTIVE_MASK;
      req_count = REQ_CNT_W'($countones(req_act));
      found     = 1'b0;
      winner    = '0;
      rule      = RULE_NONE;
      lock_out  = LOCK_NONE;
      for (int i = 0; i < ACTIVE; i++) begin
         if (!found && req_act[i] && stage_data_ff.wait_mask[i] &&
             stage_data_ff.lock_states[2*i +: LOCK_W] == LOCK_SET) begin
            found    = 1'b1;
            winner   = WIN_W'(i);
            rule     = RULE_BURST;
            lock_out = LOCK_SET;
         end
      end
      for (int i = 0; i < ACTIVE; i++) begin
         if (!found && req_act[i] &&
             stage_data_ff.lock_states[2*i +: LOCK_W] == LOCK_GRANTED) begin
            found    = 1'b1;
            winner   = WIN_W'(i);
            rule     = RULE_HELD;
            lock_out = LOCK_GRANTED;
         end
      end
      for (int i = 0; i < ACTIVE; i++) begin
         if (!found && req_act[i]) begin
            found    = 1'b1;
            winner   = WIN_W'(i);
            rule     = RULE_PRIORITY;
            lock_out = (stage_data_ff.lock_states[2*i +: LOCK_W] != LOCK_NONE) ?
                       LOCK_GRANTED : LOCK_NONE;
         end
      end
   end

   always_comb begin
      decision_cnt_in  = decision_cnt_ff;
      rejection_cnt_in = rejection_cnt_ff;
      grant_cnt_in     = sat_add(grant_cnt_ff[winner], CNT_W'(1));
      if (found) begin
         decision_cnt_in  = sat_add(decision_cnt_ff, CNT_W'(1));
         rejection_cnt_in = sat_add(rejection_cnt_ff, CNT_W'(req_count - REQ_CNT_W'(1)));
      end
      rsp_data_in.grant_index        = IDX_W'(winner);
      rsp_data_in.rule_used          = rule;
      rsp_data_in.winner_lock_out    = lock_out;
      rsp_data_in.decisions_total    = decision_cnt_in;
      rsp_data_in.rejections_total   = rejection_cnt_in;
      rsp_data_in.winner_grant_count = found ? grant_cnt_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff   <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         decision_cnt_ff  <= '0;
         rejection_cnt_ff <= '0;
         for (int i = 0; i < ACTIVE; i++) begin
            grant_cnt_ff[i] <= '0;
         end
      end else begin
         if (req_ready) begin
            stage_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= stage_valid_ff;
         end
         if (fire && found) begin
            decision_cnt_ff      <= decision_cnt_in;
            rejection_cnt_ff     <= rejection_cnt_in;
            grant_cnt_ff[winner] <= grant_cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stage_data_ff <= req_data;
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef SYNTH
   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> stage_valid_ff && rsp_valid_ff && !rsp_ready)
      else $error("request side stalled without a full pipeline");

   a_decisions_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> decision_cnt_ff >= $past(decision_cnt_ff))
      else $error("decision counter went backwards");

   a_no_grant_is_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.rule_used == RULE_NONE |->
         rsp_data_ff.grant_index == '0 && rsp_data_ff.winner_grant_count == '0 &&
         rsp_data_ff.winner_lock_out == LOCK_NONE)
      else $error("empty round reported a grant");

   a_grant_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.rule_used != RULE_NONE |->
         rsp_data_ff.winner_grant_count != '0 && rsp_data_ff.decisions_total != '0)
      else $error("grant beat without counted decision");
`endif

endmodule
